/* design/robst_pkg.sv */
// Package for the ray / oriented box slab test: payload types, field widths and
// register indexes shared by the front, queue, divider, back and top modules.
// Depends on nothing.
package robst_pkg;

  localparam int MAX_SLABS = 3;
  localparam int WORD_W    = 32;
  localparam int NRM_W     = 20;
  localparam int NRM_FRAC  = 18;
  localparam int EPS_W     = 16;
  localparam int PROD_W    = WORD_W + NRM_W;       // one component product
  localparam int DOT_W     = PROD_W + 2;           // sum of three products
  localparam int NUM_W     = DOT_W + 1;            // offset minus origin dot
  localparam int QBITS     = 31;                   // quotient bits below saturation
  localparam int DIST_W    = 31;
  localparam int DIV_LAT   = QBITS + 3;            // abs, overflow, bit stages, sign
  localparam int Q_DEPTH   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam logic signed [WORD_W-1:0] DMAX = 32'sh7FFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS_0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 3'd6;

  typedef struct packed {
    logic signed [WORD_W-1:0] org_x;
    logic signed [WORD_W-1:0] org_y;
    logic signed [WORD_W-1:0] org_z;
    logic signed [WORD_W-1:0] dir_x;
    logic signed [WORD_W-1:0] dir_y;
    logic signed [WORD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } result_t;

  // One slab after classification: skip flag, both numerators, denominator.
  typedef struct packed {
    logic                    skip;
    logic signed [NUM_W-1:0] num0;
    logic signed [NUM_W-1:0] num1;
    logic signed [DOT_W-1:0] den;
  } slab_t;

endpackage

/* design/robst_fifo.sv */
// Short queue between the front and the back of the slab test.
// Depends on robst_pkg (no types used beyond parameters given by the parent).
module robst_fifo import robst_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           din_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           dout_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH):0]     level_o
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign dout_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PTR_W + 1)'(DEPTH));
  assign level_o = cnt_q;

endmodule

/* design/robst_front.sv */
// Front of the slab test: dot products of the ray with each slab normal,
// numerators for both planes and the parallel-ray classification.
// Depends on robst_pkg.
module robst_front import robst_pkg::*; #(
  parameter int SLAB_COUNT = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  ray_t                       ray_i,
  input  logic [3*NRM_W-1:0]         normal_i  [SLAB_COUNT],
  input  logic [2*WORD_W-1:0]        offsets_i [SLAB_COUNT],
  input  logic [EPS_W-1:0]           eps_i,
  output logic                       valid_o,
  output slab_t [SLAB_COUNT-1:0]     slab_o,
  output logic [1:0]                 inflight_o
);

  logic signed [WORD_W-1:0] org [3];
  logic signed [WORD_W-1:0] dir [3];

  logic                      v1_q, v2_q, v3_q;
  logic signed [PROD_W-1:0]  pd_q [SLAB_COUNT][3];
  logic signed [PROD_W-1:0]  po_q [SLAB_COUNT][3];
  logic signed [WORD_W-1:0]  o0_q [SLAB_COUNT], o1_q [SLAB_COUNT];
  logic signed [WORD_W-1:0]  o0b_q [SLAB_COUNT], o1b_q [SLAB_COUNT];
  logic signed [DOT_W-1:0]   dn_q [SLAB_COUNT], on_q [SLAB_COUNT];
  logic signed [DOT_W-1:0]   epsw;
  slab_t [SLAB_COUNT-1:0]    slab_q;

  assign org[0] = ray_i.org_x;
  assign org[1] = ray_i.org_y;
  assign org[2] = ray_i.org_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;
  assign epsw   = DOT_W'({eps_i, {NRM_FRAC{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  for (genvar s = 0; s < SLAB_COUNT; s++) begin : g_slab
    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 3; k++) begin
        pd_q[s][k] <= PROD_W'(dir[k] * signed'(normal_i[s][NRM_W*k +: NRM_W]));
        po_q[s][k] <= PROD_W'(org[k] * signed'(normal_i[s][NRM_W*k +: NRM_W]));
      end
      o0_q[s]  <= signed'(offsets_i[s][WORD_W-1:0]);
      o1_q[s]  <= signed'(offsets_i[s][2*WORD_W-1:WORD_W]);
      dn_q[s]  <= DOT_W'(pd_q[s][0]) + DOT_W'(pd_q[s][1]) + DOT_W'(pd_q[s][2]);
      on_q[s]  <= DOT_W'(po_q[s][0]) + DOT_W'(po_q[s][1]) + DOT_W'(po_q[s][2]);
      o0b_q[s] <= o0_q[s];
      o1b_q[s] <= o1_q[s];
      slab_q[s].num0 <= (NUM_W'(o0b_q[s]) <<< NRM_FRAC) - NUM_W'(on_q[s]);
      slab_q[s].num1 <= (NUM_W'(o1b_q[s]) <<< NRM_FRAC) - NUM_W'(on_q[s]);
      slab_q[s].den  <= dn_q[s];
      // A zero dot product is always skipped, whatever the threshold.
      slab_q[s].skip <= (dn_q[s] == '0) || ((dn_q[s] < epsw) && (dn_q[s] > -epsw));
    end
  end

  assign valid_o    = v3_q;
  assign slab_o     = slab_q;
  assign inflight_o = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);

endmodule

/* design/robst_div.sv */
// Pipelined signed divider: num * 2^FRAC_BITS / den, truncated toward zero and
// saturated to the largest distance. One quotient bit per stage. Uses robst_pkg.
module robst_div import robst_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [NUM_W-1:0]    num_i,
  input  logic signed [DOT_W-1:0]    den_i,
  output logic                       valid_o,
  output logic signed [WORD_W-1:0]   quo_o
);

  localparam int RW = DOT_W + QBITS;

  logic                 va_q;
  logic [NUM_W-1:0]     a_q;
  logic [DOT_W-1:0]     ba_q;
  logic                 nega_q;

  logic                 v_q   [QBITS+1];
  logic [RW-1:0]        rem_q [QBITS+1];
  logic [QBITS-1:0]     q_q   [QBITS+1];
  logic [DOT_W-1:0]     b_q   [QBITS+1];
  logic                 neg_q [QBITS+1];
  logic                 ovf_q [QBITS+1];

  logic                 vo_q;
  logic signed [WORD_W-1:0] quo_q;
  logic [RW-1:0]        rem0;
  logic [QBITS-1:0]     mag;

  always_ff @(posedge clk_i) begin
    a_q    <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    ba_q   <= den_i[DOT_W-1] ? DOT_W'(-den_i) : DOT_W'(den_i);
    nega_q <= num_i[NUM_W-1] ^ den_i[DOT_W-1];
  end

  assign rem0 = RW'({a_q, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk_i) begin
    rem_q[0] <= rem0;
    q_q[0]   <= '0;
    b_q[0]   <= ba_q;
    neg_q[0] <= nega_q;
    // Quotient would need more than QBITS bits: saturate.
    ovf_q[0] <= rem0 >= RW'({ba_q, {QBITS{1'b0}}});
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_bit
    logic [RW:0] trial;
    assign trial = {1'b0, rem_q[j-1]} - {1'b0, RW'(b_q[j-1]) << (QBITS - j)};
    always_ff @(posedge clk_i) begin
      rem_q[j] <= trial[RW] ? rem_q[j-1] : trial[RW-1:0];
      q_q[j]   <= q_q[j-1] | (QBITS'(!trial[RW]) << (QBITS - j));
      b_q[j]   <= b_q[j-1];
      neg_q[j] <= neg_q[j-1];
      ovf_q[j] <= ovf_q[j-1];
    end
  end

  assign mag = ovf_q[QBITS] ? QBITS'(DMAX) : q_q[QBITS];

  always_ff @(posedge clk_i) begin
    quo_q <= neg_q[QBITS] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vo_q <= 1'b0;
      for (int j = 0; j <= QBITS; j++) begin
        v_q[j] <= 1'b0;
      end
    end else begin
      va_q <= valid_i;
      v_q[0] <= va_q;
      for (int j = 1; j <= QBITS; j++) begin
        v_q[j] <= v_q[j-1];
      end
      vo_q <= v_q[QBITS];
    end
  end

  assign valid_o = vo_q;
  assign quo_o   = quo_q;

endmodule

/* design/robst_back.sv */
// Back of the slab test: two pipelined divisions per slab, ordering of the
// plane hits, narrowing of [tmin, tmax] and the final hit decision.
// Depends on robst_pkg and robst_div.
module robst_back import robst_pkg::*; #(
  parameter int SLAB_COUNT = 3,
  parameter int FRAC_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  slab_t [SLAB_COUNT-1:0]     slab_i,
  input  logic [EPS_W-1:0]           eps_i,
  output logic                       valid_o,
  output result_t                    result_o
);

  logic [SLAB_COUNT-1:0]    skip_q [DIV_LAT];
  logic [SLAB_COUNT-1:0]    dv;
  logic signed [WORD_W-1:0] t0 [SLAB_COUNT], t1 [SLAB_COUNT];
  logic signed [WORD_W-1:0] lo_q [SLAB_COUNT], hi_q [SLAB_COUNT];
  logic signed [WORD_W-1:0] tmin_q, tmax_q, tmin, tmax, eps_s;
  logic                     vo_q, vr_q, vh_q;
  result_t                  res_q;

  for (genvar s = 0; s < SLAB_COUNT; s++) begin : g_slab
    logic unused_v;
    robst_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
      .clk_i, .rst_ni, .valid_i(valid_i), .num_i(slab_i[s].num0),
      .den_i(slab_i[s].den), .valid_o(dv[s]), .quo_o(t0[s])
    );
    robst_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
      .clk_i, .rst_ni, .valid_i(valid_i), .num_i(slab_i[s].num1),
      .den_i(slab_i[s].den), .valid_o(unused_v), .quo_o(t1[s])
    );

    always_ff @(posedge clk_i) begin
      if (skip_q[DIV_LAT-1][s] || unused_v != dv[s]) begin
        lo_q[s] <= -DMAX;
        hi_q[s] <= DMAX;
      end else if (t1[s] < t0[s]) begin
        lo_q[s] <= t1[s];
        hi_q[s] <= t0[s];
      end else begin
        lo_q[s] <= t0[s];
        hi_q[s] <= t1[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SLAB_COUNT; s++) begin
      skip_q[0][s] <= slab_i[s].skip;
    end
    for (int k = 1; k < DIV_LAT; k++) begin
      skip_q[k] <= skip_q[k-1];
    end
  end

  always_comb begin
    tmin = -DMAX;
    tmax = DMAX;
    for (int s = 0; s < SLAB_COUNT; s++) begin
      if (lo_q[s] > tmin) tmin = lo_q[s];
      if (hi_q[s] < tmax) tmax = hi_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    tmin_q <= tmin;
    tmax_q <= tmax;
  end

  assign eps_s = signed'(WORD_W'(eps_i));

  // If tmin is below epsilon, tmax gives the distance and must clear epsilon.
  always_ff @(posedge clk_i) begin
    res_q.hit      <= 1'b0;
    res_q.distance <= '0;
    if (tmin_q < tmax_q) begin
      if (tmin_q < eps_s) begin
        if (tmax_q > eps_s) begin
          res_q.hit      <= 1'b1;
          res_q.distance <= tmax_q[DIST_W-1:0];
        end
      end else begin
        res_q.hit      <= 1'b1;
        res_q.distance <= tmin_q[DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
      vr_q <= 1'b0;
      vh_q <= 1'b0;
    end else begin
      vo_q <= dv[0];
      vr_q <= vo_q;
      vh_q <= vr_q;
    end
  end

  assign valid_o  = vh_q;
  assign result_o = res_q;

endmodule

/* design/ray_oriented_box_slab_test.sv */
// Top level of the ray / oriented box slab test: configuration registers,
// front, queue and back. Depends on robst_pkg, robst_front, robst_fifo, robst_back.
//
// Usage. A ray word (origin and direction, signed fixed point) is offered on
// ray_i with start_i high; it is taken at a rising edge where busy_o is low.
// Exactly one result word (hit flag, distance) appears on result_o for one
// cycle with done_o high, in the order the rays were taken. The receiver cannot
// hold results off, and the block never needs it to: the back never stalls.
// Throughput is one ray per clock while busy_o is low. A ray passes through
// three front stages, the queue, the divider pipeline (one stage per quotient
// bit plus abs, overflow and sign stages) and three stages for ordering,
// narrowing and the hit decision.
// busy_o rises only if the queue could overflow; with the back draining one
// word per cycle it stays low. The user writes configuration via cfg_we_i /
// cfg_idx_i / cfg_data_i only while the block is idle, which is not enforced.
// Writes to slabs beyond SLAB_COUNT or unknown indexes are dropped. Reset
// clears normals and offsets and sets epsilon to seven.
module ray_oriented_box_slab_test import robst_pkg::*; #(
  parameter int SLAB_COUNT = 3,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  ray_t                   ray_i,
  output logic                   done_o,
  output result_t                result_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int LVL_W = $clog2(Q_DEPTH) + 1;
  localparam int SLAB_W = $bits(slab_t) * SLAB_COUNT;

  logic [3*NRM_W-1:0]    normal_q  [SLAB_COUNT];
  logic [2*WORD_W-1:0]   offsets_q [SLAB_COUNT];
  logic [EPS_W-1:0]      eps_q;

  logic                  accept;
  logic                  fifo_push, fifo_empty, fifo_full;
  logic [LVL_W-1:0]      fifo_level;
  logic [1:0]            inflight;
  slab_t [SLAB_COUNT-1:0] front_slab, back_slab;

  // Configuration registers: each slab register sits at its base plus slab.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLAB_COUNT; s++) begin
        normal_q[s]  <= '0;
        offsets_q[s] <= '0;
      end
      eps_q <= EPS_W'(7);
    end else if (cfg_we_i) begin
      for (int s = 0; s < SLAB_COUNT; s++) begin
        if (cfg_idx_i == REG_NORMAL_0 + CFG_IDX_W'(s)) begin
          normal_q[s] <= cfg_data_i[3*NRM_W-1:0];
        end
        if (cfg_idx_i == REG_OFFSETS_0 + CFG_IDX_W'(s)) begin
          offsets_q[s] <= cfg_data_i[2*WORD_W-1:0];
        end
      end
      if (cfg_idx_i == REG_EPSILON) begin
        eps_q <= cfg_data_i[EPS_W-1:0];
      end
    end
  end

  assign accept = start_i && !busy_o;
  // Hold off only when everything in the front might not fit in the queue.
  assign busy_o = ((LVL_W + 1)'(fifo_level) + (LVL_W + 1)'(inflight))
                  >= (LVL_W + 1)'(Q_DEPTH);

  robst_front #(.SLAB_COUNT(SLAB_COUNT)) u_front (
    .clk_i, .rst_ni,
    .valid_i    (accept),
    .ray_i      (ray_i),
    .normal_i   (normal_q),
    .offsets_i  (offsets_q),
    .eps_i      (eps_q),
    .valid_o    (fifo_push),
    .slab_o     (front_slab),
    .inflight_o (inflight)
  );

  robst_fifo #(.WIDTH(SLAB_W), .DEPTH(Q_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (fifo_push),
    .din_i   (front_slab),
    .pop_i   (!fifo_empty),
    .dout_o  (back_slab),
    .empty_o (fifo_empty),
    .full_o  (fifo_full),
    .level_o (fifo_level)
  );

  robst_back #(.SLAB_COUNT(SLAB_COUNT), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i  (!fifo_empty),
    .slab_i   (back_slab),
    .eps_i    (eps_q),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  // Every accepted ray reaches the queue after the three front stages.
  a_front_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 fifo_push) else $error("ray lost in the front");

  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full) else $error("queue overflow");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.hit) |-> (result_o.distance == '0))
    else $error("miss with non-zero distance");

  a_hit_eps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.hit) |-> (result_o.distance >= DIST_W'(eps_q)))
    else $error("hit closer than epsilon");

endmodule
